// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is asserted.
`define SWDH_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("swdh assertion failed");

// Concurrent check that also runs through reset.
`define SWDH_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("swdh assertion failed");

`endif

// ===== hdl/swdh_pkg.sv =====
// ----------------------------------------------------------------------------
// swdh_pkg
// Types and constants of the SWD host transaction engine.
// ----------------------------------------------------------------------------
package swdh_pkg;

  localparam int RESET_ONES_DEF = 64;

  localparam logic [15:0] SWITCH_KEY = 16'hE79E;
  localparam logic [2:0]  ACK_OK     = 3'b001;
  localparam logic [2:0]  ACK_NONE   = 3'b111;

  // action codes
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_WRITE  = 2'd2;
  localparam logic [1:0] ACT_SWITCH = 2'd3;

  // switch sequence segments
  localparam logic [1:0] SEG_ONES_A = 2'd0;
  localparam logic [1:0] SEG_KEY    = 2'd1;
  localparam logic [1:0] SEG_ONES_B = 2'd2;
  localparam logic [1:0] SEG_ZEROS  = 2'd3;

  // phase lengths in SWCLK cycles
  localparam int REQ_LEN   = 8;
  localparam int ACK_LEN   = 3;
  localparam int WDATA_LEN = 33;
  localparam int RDATA_LEN = 34;
  localparam int KEY_LEN   = 16;
  localparam int ZERO_LEN  = 8;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_REQ    = 3'd1,
    PH_TURN   = 3'd2,
    PH_ACK    = 3'd3,
    PH_TURN2  = 3'd4,
    PH_RDATA  = 3'd5,
    PH_WDATA  = 3'd6,
    PH_SWITCH = 3'd7
  } phase_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        port_ap;
    logic [1:0]  reg_addr;
    logic [31:0] write_data;
    logic        swdio_in;
  } in_t;

  typedef struct packed {
    logic        swdio_out;
    logic        swdio_drive;
    logic        clock_pulse;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  ack;
    logic        parity_error;
    logic [31:0] read_data;
  } out_t;

endpackage

// ===== hdl/swd_host_transaction_engine.sv =====
// ----------------------------------------------------------------------------
// swd_host_transaction_engine
// Bit-level SWD host: request, ack, data phases and the line switch sequence.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | in_t   (action, request, SWDIO in)
//   out_    | output    | out_valid/out_stall | out_t  (pin levels, status, data)
//   cfg_    | input     | cfg_valid/cfg_ready | proceed_on_no_reply
//
// One item per clock while in_stall is low; its result is registered.
// A two-entry output buffer lets one more item in while a result is stalled;
// in_stall rises only when both entries are full.
// Synchronous active-low reset; config writes are always ready.
// ----------------------------------------------------------------------------
module swd_host_transaction_engine import swdh_pkg::*; #(
  parameter int RESET_ONES = RESET_ONES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  logic proceed_r;
  logic in_fire;
  logic out_take;
  logic out_v_r;
  logic skid_v_r;
  out_t out_r;
  out_t skid_r;
  out_t res;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_v_r;
  assign in_fire   = in_valid && !skid_v_r;
  assign out_take  = out_v_r && !out_stall;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proceed_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      proceed_r <= cfg_data;
    end
  end

  swdh_core #(
    .RESET_ONES(RESET_ONES)
  ) u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .step               (in_fire),
    .item               (in_data),
    .proceed_on_no_reply(proceed_r),
    .res                (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) skid_v_r <= 1'b0;
    end else if (in_fire) begin
      if (out_v_r && !out_take) skid_v_r <= 1'b1;
      out_v_r <= 1'b1;
    end else if (out_take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) out_r <= skid_r;
    end else if (in_fire) begin
      if (!out_v_r || out_take) out_r  <= res;
      else                      skid_r <= res;
    end
  end

endmodule

// ===== hdl/swdh_core.sv =====
// ----------------------------------------------------------------------------
// swdh_core
// Protocol sequencer: one state update and one result per accepted item.
// ----------------------------------------------------------------------------
module swdh_core import swdh_pkg::*; #(
  parameter int RESET_ONES = RESET_ONES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  in_t  item,
  input  logic proceed_on_no_reply,
  output out_t res
);

  localparam int CNT_MAX = (RESET_ONES > RDATA_LEN) ? RESET_ONES : RDATA_LEN;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  localparam logic [CNT_W-1:0] ONES_LEN  = CNT_W'(RESET_ONES);
  localparam logic [CNT_W-1:0] REQ_END   = CNT_W'(REQ_LEN);
  localparam logic [CNT_W-1:0] ACK_END   = CNT_W'(ACK_LEN);
  localparam logic [CNT_W-1:0] WDATA_END = CNT_W'(WDATA_LEN);
  localparam logic [CNT_W-1:0] RDATA_END = CNT_W'(RDATA_LEN);
  localparam logic [CNT_W-1:0] RDATA_LST = CNT_W'(RDATA_LEN - 1);
  localparam logic [CNT_W-1:0] KEY_END   = CNT_W'(KEY_LEN);
  localparam logic [CNT_W-1:0] ZERO_END  = CNT_W'(ZERO_LEN);

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       req_r, req_nxt;
  logic [32:0]      data_r, data_nxt;
  logic [31:0]      pend_r, pend_nxt;
  logic [31:0]      rword_r, rword_nxt;
  logic [2:0]       ack_r, ack_nxt;
  logic [1:0]       seg_r, seg_nxt;
  logic             is_read_r, is_read_nxt;
  logic             pbad_r, pbad_nxt;

  logic             tick;
  logic [CNT_W-1:0] cnt_inc;
  logic [2:0]       ack_new;
  logic             go_new;
  logic             go_cur;
  logic             rnw;
  logic             req_par;
  logic             finish;
  logic             so;
  logic             drv;

  assign tick    = (item.action == ACT_TICK) && (phase_r != PH_IDLE);
  assign cnt_inc = cnt_r + 1'b1;
  assign ack_new = ack_r | (3'(item.swdio_in) << cnt_r[1:0]);
  assign go_new  = (ack_new == ACK_OK) || ((ack_new == ACK_NONE) && proceed_on_no_reply);
  assign go_cur  = (ack_r == ACK_OK) || ((ack_r == ACK_NONE) && proceed_on_no_reply);
  assign rnw     = (item.action == ACT_READ);
  assign req_par = item.port_ap ^ rnw ^ item.reg_addr[0] ^ item.reg_addr[1];

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    req_nxt     = req_r;
    data_nxt    = data_r;
    pend_nxt    = pend_r;
    rword_nxt   = rword_r;
    ack_nxt     = ack_r;
    seg_nxt     = seg_r;
    is_read_nxt = is_read_r;
    pbad_nxt    = pbad_r;
    finish      = 1'b0;
    if (item.action != ACT_TICK) begin
      if (phase_r == PH_IDLE) begin
        ack_nxt  = '0;
        pbad_nxt = 1'b0;
        cnt_nxt  = '0;
        if (item.action == ACT_SWITCH) begin
          phase_nxt = PH_SWITCH;
          seg_nxt   = SEG_ONES_A;
        end else begin
          is_read_nxt = rnw;
          pend_nxt    = item.write_data;
          // park, stop, parity, A3, A2, RnW, APnDP, start
          req_nxt     = {1'b1, 1'b0, req_par, item.reg_addr, rnw, item.port_ap, 1'b1};
          phase_nxt   = PH_REQ;
        end
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_REQ: begin
          req_nxt = {1'b0, req_r[7:1]};
          cnt_nxt = cnt_inc;
          if (cnt_inc == REQ_END) begin
            cnt_nxt   = '0;
            phase_nxt = PH_TURN;
          end
        end
        PH_TURN: begin
          phase_nxt = PH_ACK;
          cnt_nxt   = '0;
        end
        PH_ACK: begin
          ack_nxt = ack_new;
          cnt_nxt = cnt_inc;
          if (cnt_inc == ACK_END) begin
            cnt_nxt = '0;
            if (is_read_r && go_new) begin
              data_nxt  = '0;
              phase_nxt = PH_RDATA;
            end else begin
              phase_nxt = PH_TURN2;
            end
          end
        end
        PH_TURN2: begin
          if (!is_read_r && go_cur) begin
            // no reply: drive zeros for data and parity
            data_nxt  = (ack_r == ACK_NONE) ? '0 : {^pend_r, pend_r};
            cnt_nxt   = '0;
            phase_nxt = PH_WDATA;
          end else begin
            finish = 1'b1;
          end
        end
        PH_WDATA: begin
          data_nxt = {1'b0, data_r[32:1]};
          cnt_nxt  = cnt_inc;
          if (cnt_inc == WDATA_END) finish = 1'b1;
        end
        PH_RDATA: begin
          cnt_nxt = cnt_inc;
          if (cnt_r != RDATA_LST) data_nxt = {item.swdio_in, data_r[32:1]};
          if (cnt_inc == RDATA_END) begin
            rword_nxt = data_r[31:0];
            pbad_nxt  = (^data_r[31:0]) ^ data_r[32];
            finish    = 1'b1;
          end
        end
        PH_SWITCH: begin
          cnt_nxt = cnt_inc;
          if ((((seg_r == SEG_ONES_A) || (seg_r == SEG_ONES_B)) && (cnt_inc == ONES_LEN)) ||
              ((seg_r == SEG_KEY) && (cnt_inc == KEY_END)) ||
              ((seg_r == SEG_ZEROS) && (cnt_inc == ZERO_END))) begin
            cnt_nxt = '0;
            if (seg_r == SEG_ZEROS) finish = 1'b1;
            else seg_nxt = seg_r + 1'b1;
          end
        end
      endcase
      if (finish) begin
        phase_nxt = PH_IDLE;
        cnt_nxt   = '0;
      end
    end
  end

  // pin levels for this cycle
  always_comb begin
    so  = 1'b0;
    drv = 1'b0;
    unique case (phase_r)
      PH_REQ: begin
        so  = req_r[0];
        drv = 1'b1;
      end
      PH_WDATA: begin
        so  = data_r[0];
        drv = 1'b1;
      end
      PH_SWITCH: begin
        drv = 1'b1;
        case (seg_r)
          SEG_KEY:   so = SWITCH_KEY[cnt_r[3:0]];
          SEG_ZEROS: so = 1'b0;
          default:   so = 1'b1;
        endcase
      end
      PH_IDLE, PH_TURN, PH_ACK, PH_TURN2, PH_RDATA: begin
      end
    endcase
    res.swdio_out    = so & tick;
    res.swdio_drive  = drv & tick;
    res.clock_pulse  = tick;
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.done_res     = tick & (phase_nxt == PH_IDLE);
    res.ack          = ack_nxt;
    res.parity_error = pbad_nxt;
    res.read_data    = rword_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cnt_r     <= '0;
      rword_r   <= '0;
      ack_r     <= '0;
      seg_r     <= SEG_ONES_A;
      is_read_r <= 1'b0;
      pbad_r    <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      rword_r   <= rword_nxt;
      ack_r     <= ack_nxt;
      seg_r     <= seg_nxt;
      is_read_r <= is_read_nxt;
      pbad_r    <= pbad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      req_r  <= req_nxt;
      data_r <= data_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

// ===== hdl/swdh_checker.sv =====
// ----------------------------------------------------------------------------
// swdh_checker
// Port-level checks of the SWD host transaction engine, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swdh_checker import swdh_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // a stalled result holds
  `SWDH_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data))
  // every accepted item leaves a result pending on the next cycle
  `SWDH_ASSERT(a_in_to_out, clk, rst_n, in_valid && !in_stall |=> out_valid)
  // back-pressure only with a result waiting
  `SWDH_ASSERT(a_stall_pend, clk, rst_n, in_stall |-> out_valid)
  // reset empties the output buffer
  `SWDH_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid && !in_stall)

endmodule

bind swd_host_transaction_engine swdh_checker u_swdh_checker (.*);
